/* design/t55wg_pkg.sv */
// t55wg_pkg: shared types, codes and timing constants for the t55xx write
// gap modulator. No dependencies; imported by every module of the block.
package t55wg_pkg;

  localparam int CLK_W    = 10;
  localparam int SHORT_W  = 8;
  localparam int BITS_W   = 6;
  localparam int FRAME_W  = 38;
  localparam int DATA_W   = 32;
  localparam int CIDX_W   = 3;

  localparam logic [BITS_W-1:0]  FRAME_BITS   = BITS_W'(FRAME_W);
  localparam logic [BITS_W-1:0]  RST_CMD_BITS = 6'd2;
  // reset command: bits 1 then 0, left aligned in the frame
  localparam logic [FRAME_W-1:0] RESET_FRAME  = {2'b10, 36'd0};

  // request selector carried in tuser
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_RESET = 2'd2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_WAIT  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_SGAP  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_WGAP  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_ZERO  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_ONE   = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_PROG  = 3'd5;

  localparam logic [CLK_W-1:0]   WAIT_RST  = 10'd400;
  localparam logic [SHORT_W-1:0] SGAP_RST  = 8'd30;
  localparam logic [SHORT_W-1:0] WGAP_RST  = 8'd18;
  localparam logic [SHORT_W-1:0] ZERO_RST  = 8'd24;
  localparam logic [SHORT_W-1:0] ONE_RST   = 8'd56;
  localparam logic [CLK_W-1:0]   PROG_RST  = 10'd700;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WAIT1 = 3'd1,
    PH_SGAP  = 3'd2,
    PH_BON   = 3'd3,
    PH_BGAP  = 3'd4,
    PH_PROG  = 3'd5,
    PH_WAIT2 = 3'd6
  } phase_t;

  typedef struct packed {
    logic [CLK_W-1:0]   wait_clocks;
    logic [SHORT_W-1:0] start_gap_clocks;
    logic [SHORT_W-1:0] write_gap_clocks;
    logic [SHORT_W-1:0] zero_on_clocks;
    logic [SHORT_W-1:0] one_on_clocks;
    logic [CLK_W-1:0]   program_clocks;
  } cfg_t;

  typedef struct packed {
    logic rejected;
    logic done_res;
    logic busy_res;
    logic field_on;
  } res_t;

  // length of a phase in field clocks, a zero setting lasts one clock
  function automatic logic [CLK_W-1:0] phase_len(phase_t ph, logic bit_msb, cfg_t cfg);
    logic [CLK_W-1:0] len;
    len = CLK_W'(1);
    case (ph)
      PH_WAIT1, PH_WAIT2: len = cfg.wait_clocks;
      PH_SGAP:  len = CLK_W'(cfg.start_gap_clocks);
      PH_BON:   len = bit_msb ? CLK_W'(cfg.one_on_clocks) : CLK_W'(cfg.zero_on_clocks);
      PH_BGAP:  len = CLK_W'(cfg.write_gap_clocks);
      PH_PROG:  len = cfg.program_clocks;
      default:  len = CLK_W'(1);
    endcase
    if (len == '0) begin
      len = CLK_W'(1);
    end
    return len;
  endfunction

endpackage

/* design/t55wg_cfg_regs.sv */
// t55wg_cfg_regs: the six timing registers behind the configuration port.
// Depends on t55wg_pkg.
module t55wg_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [t55wg_pkg::CIDX_W-1:0]  wr_index,
  input  logic [t55wg_pkg::CLK_W-1:0]   wr_data,
  output t55wg_pkg::cfg_t               cfg
);
  import t55wg_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_WAIT: cfg_nxt.wait_clocks      = wr_data;
        CFG_SGAP: cfg_nxt.start_gap_clocks = wr_data[SHORT_W-1:0];
        CFG_WGAP: cfg_nxt.write_gap_clocks = wr_data[SHORT_W-1:0];
        CFG_ZERO: cfg_nxt.zero_on_clocks   = wr_data[SHORT_W-1:0];
        CFG_ONE:  cfg_nxt.one_on_clocks    = wr_data[SHORT_W-1:0];
        CFG_PROG: cfg_nxt.program_clocks   = wr_data;
        default:  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wait_clocks      <= WAIT_RST;
      cfg_r.start_gap_clocks <= SGAP_RST;
      cfg_r.write_gap_clocks <= WGAP_RST;
      cfg_r.zero_on_clocks   <= ZERO_RST;
      cfg_r.one_on_clocks    <= ONE_RST;
      cfg_r.program_clocks   <= PROG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/t55wg_seq.sv */
// t55wg_seq: command sequencer, holds phase, clock and bit counters and the
// frame shifter, and steps once per input beat. Depends on t55wg_pkg.
module t55wg_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  logic [1:0]                    req_type,
  input  logic                          page_sel,
  input  logic [2:0]                    block_addr,
  input  logic                          lock_flag,
  input  logic [t55wg_pkg::DATA_W-1:0]  block_data,
  input  t55wg_pkg::cfg_t               cfg,
  output t55wg_pkg::res_t               res
);
  import t55wg_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [CLK_W-1:0]     clocks_r, clocks_nxt;
  logic [BITS_W-1:0]    bits_r, bits_nxt;
  logic [FRAME_W-1:0]   frame_r, frame_nxt;
  logic                 pend_r, pend_nxt;
  logic                 is_req;

  always_comb begin
    phase_nxt  = phase_r;
    clocks_nxt = clocks_r;
    bits_nxt   = bits_r;
    frame_nxt  = frame_r;
    pend_nxt   = pend_r;
    res        = '0;
    res.field_on = 1'b1;
    is_req = (req_type == REQ_WRITE) || (req_type == REQ_RESET);

    // a request accepted while idle is already the first clock of its sequence
    if (is_req) begin
      if (phase_r != PH_IDLE) begin
        res.rejected = 1'b1;
      end else if (req_type == REQ_WRITE) begin
        frame_nxt  = {1'b1, page_sel, lock_flag, block_data, block_addr};
        bits_nxt   = FRAME_BITS;
        pend_nxt   = 1'b1;
        phase_nxt  = PH_WAIT1;
        clocks_nxt = phase_len(PH_WAIT1, 1'b0, cfg);
      end else begin
        frame_nxt  = RESET_FRAME;
        bits_nxt   = RST_CMD_BITS;
        pend_nxt   = 1'b0;
        phase_nxt  = PH_SGAP;
        clocks_nxt = phase_len(PH_SGAP, 1'b0, cfg);
      end
    end

    if (phase_nxt != PH_IDLE) begin
      res.busy_res = 1'b1;
      res.field_on = (phase_nxt == PH_WAIT1) || (phase_nxt == PH_BON) ||
                     (phase_nxt == PH_PROG)  || (phase_nxt == PH_WAIT2);
      clocks_nxt = clocks_nxt - CLK_W'(1);
      if (clocks_nxt == '0) begin
        case (phase_nxt)
          PH_WAIT1: begin
            phase_nxt  = PH_SGAP;
            clocks_nxt = phase_len(PH_SGAP, 1'b0, cfg);
          end
          PH_SGAP: begin
            phase_nxt  = PH_BON;
            clocks_nxt = phase_len(PH_BON, frame_nxt[FRAME_W-1], cfg);
          end
          PH_BON: begin
            phase_nxt  = PH_BGAP;
            clocks_nxt = phase_len(PH_BGAP, 1'b0, cfg);
          end
          PH_BGAP: begin
            frame_nxt = {frame_nxt[FRAME_W-2:0], 1'b0};
            bits_nxt  = bits_nxt - BITS_W'(1);
            if (bits_nxt != '0) begin
              phase_nxt  = PH_BON;
              clocks_nxt = phase_len(PH_BON, frame_nxt[FRAME_W-1], cfg);
            end else if (pend_nxt) begin
              phase_nxt  = PH_PROG;
              clocks_nxt = phase_len(PH_PROG, 1'b0, cfg);
            end else begin
              phase_nxt    = PH_IDLE;
              res.done_res = 1'b1;
            end
          end
          PH_PROG: begin
            phase_nxt  = PH_WAIT2;
            clocks_nxt = phase_len(PH_WAIT2, 1'b0, cfg);
          end
          PH_WAIT2: begin
            // programming done, follow with the reset command
            frame_nxt  = RESET_FRAME;
            bits_nxt   = RST_CMD_BITS;
            pend_nxt   = 1'b0;
            phase_nxt  = PH_SGAP;
            clocks_nxt = phase_len(PH_SGAP, 1'b0, cfg);
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      clocks_r <= '0;
      bits_r   <= '0;
      frame_r  <= '0;
      pend_r   <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      clocks_r <= clocks_nxt;
      bits_r   <= bits_nxt;
      frame_r  <= frame_nxt;
      pend_r   <= pend_nxt;
    end
  end

  a_idle_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (clocks_r == '0))
    else $error("idle sequencer holds a nonzero clock count");

  a_run_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (clocks_r != '0))
    else $error("running phase with an empty clock count");

  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res.done_res) |=> (phase_r == PH_IDLE))
    else $error("sequence reported done but did not return to idle");

endmodule

/* design/t55xx_write_gap_modulator.sv */
// t55xx_write_gap_modulator: top level, input beat register, sequencer and
// result register. Depends on t55wg_pkg, t55wg_cfg_regs and t55wg_seq.
// The input beat register holds an accepted beat; the sequencer steps on it
// combinationally and the result register captures its result.
// Throughput: one beat per cycle unless the result stream stalls.
// An empty input register takes a new beat in while a result waits.
// Reset (rst_n low, synchronous): sequencer idle, timing registers to defaults.
module t55xx_write_gap_modulator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // page_sel[0], block_addr[3:1], lock_flag[4],
                                  // block_data[36:5], zero pad [39:37]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // field_on[0], busy_res[1], done_res[2],
                                  // rejected[3], zero pad [7:4]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [t55wg_pkg::CIDX_W-1:0] cfg_index,
  input  logic [t55wg_pkg::CLK_W-1:0]  cfg_data
);
  import t55wg_pkg::*;

  logic        in_vld_r, in_vld_nxt;
  logic [36:0] in_data_r;
  logic [1:0]  in_req_r;
  logic        out_vld_r, out_vld_nxt;
  res_t        out_res_r;
  res_t        step_res;
  cfg_t        cfg;
  logic        advance;
  logic        step_en;

  assign cfg_ready = 1'b1;

  t55wg_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign advance   = !out_vld_r || out_tready;
  assign step_en   = in_vld_r && advance;
  assign in_tready = !in_vld_r || advance;

  t55wg_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .req_type   (in_req_r),
    .page_sel   (in_data_r[0]),
    .block_addr (in_data_r[3:1]),
    .lock_flag  (in_data_r[4]),
    .block_data (in_data_r[36:5]),
    .cfg        (cfg),
    .res        (step_res)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_tready) begin
      in_vld_nxt = in_tvalid;
    end
    out_vld_nxt = out_vld_r;
    if (step_en) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata[36:0];
      in_req_r  <= in_tuser;
    end
    if (step_en) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, out_res_r};

endmodule

/* verif/tb_top.sv */
// tb_top: self-checking bench for the t55xx write gap modulator, drives tick and
// request beats with random idling on both streams and checks every gate result.
// Depends on t55wg_pkg and t55xx_write_gap_modulator.
module tb_top;
  import t55wg_pkg::*;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam logic [CIDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_SPARE_HI = 3'd7;

  // gate results that can be read off directly: {rejected, done, busy, field}
  localparam res_t RES_IDLE    = 4'b0001;
  localparam res_t RES_GAP     = 4'b0010;
  localparam res_t RES_GAP_REJ = 4'b1010;
  localparam res_t RES_WAIT    = 4'b0011;

  typedef enum logic [1:0] {ROW_BEAT, ROW_FINISH, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [1:0]        req;
    logic              page;
    logic [2:0]        addr;
    logic              lock;
    logic [31:0]       data;
    logic [CIDX_W-1:0] idx;
    logic [CLK_W-1:0]  val;
    logic              known;
    res_t              res;
  } row_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [39:0]         in_tdata;
  logic [1:0]          in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [7:0]          out_tdata;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index;
  logic [CLK_W-1:0]    cfg_data;

  // mirror of the sequencer and its timing registers
  cfg_t                seq_cfg;
  phase_t              seq_ph;
  logic [CLK_W-1:0]    seq_left;
  logic [BITS_W-1:0]   seq_bits;
  logic [FRAME_W-1:0]  seq_frame;
  logic                seq_reprog;

  res_t                gate_q[$];
  row_t                plan[$];
  bit                  quiet;
  int unsigned         n_beats, n_writes, n_resets, n_rejects, n_checked, n_errors;

  t55xx_write_gap_modulator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void seq_enter(phase_t ph);
    logic [CLK_W-1:0] n;
    case (ph)
      PH_WAIT1, PH_WAIT2: n = seq_cfg.wait_clocks;
      PH_SGAP: n = CLK_W'(seq_cfg.start_gap_clocks);
      PH_BON: n = seq_frame[FRAME_W-1] ? CLK_W'(seq_cfg.one_on_clocks)
                                       : CLK_W'(seq_cfg.zero_on_clocks);
      PH_BGAP: n = CLK_W'(seq_cfg.write_gap_clocks);
      PH_PROG: n = seq_cfg.program_clocks;
      default: n = '0;
    endcase
    seq_ph = ph;
    seq_left = (ph == PH_IDLE) ? '0 : ((n == '0) ? CLK_W'(1) : n);
  endfunction

  function automatic void seq_load_reset_cmd();
    seq_frame = RESET_FRAME;
    seq_bits = RST_CMD_BITS;
    seq_reprog = 1'b0;
    seq_enter(PH_SGAP);
  endfunction

  // one field clock of the sequencer, returns the gate result for it
  function automatic res_t gate_predict(logic [1:0] req, logic page, logic [2:0] addr,
                                        logic lock, logic [31:0] data);
    res_t r;
    r = RES_IDLE;
    if (req == REQ_WRITE || req == REQ_RESET) begin
      if (seq_ph != PH_IDLE) begin
        r.rejected = 1'b1;
      end else if (req == REQ_WRITE) begin
        seq_frame = {1'b1, page, lock, data, addr};
        seq_bits = FRAME_BITS;
        seq_reprog = 1'b1;
        seq_enter(PH_WAIT1);
      end else begin
        seq_load_reset_cmd();
      end
    end
    if (seq_ph != PH_IDLE) begin
      r.busy_res = 1'b1;
      r.field_on = seq_ph inside {PH_WAIT1, PH_BON, PH_PROG, PH_WAIT2};
      seq_left = seq_left - CLK_W'(1);
      if (seq_left == '0) begin
        case (seq_ph)
          PH_WAIT1: seq_enter(PH_SGAP);
          PH_SGAP:  seq_enter(PH_BON);
          PH_BON:   seq_enter(PH_BGAP);
          PH_BGAP: begin
            seq_frame = seq_frame << 1;
            seq_bits = seq_bits - BITS_W'(1);
            if (seq_bits != '0) begin
              seq_enter(PH_BON);
            end else if (seq_reprog) begin
              seq_enter(PH_PROG);
            end else begin
              seq_ph = PH_IDLE;
              r.done_res = 1'b1;
            end
          end
          PH_PROG:  seq_enter(PH_WAIT2);
          PH_WAIT2: seq_load_reset_cmd();
          default:  seq_ph = PH_IDLE;
        endcase
      end
    end
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (quiet || p < 60) return 0;
    if (p < 88) return $urandom_range(3, 1);
    if (p < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic row_t beat_row(logic [1:0] req, logic page, logic [2:0] addr,
                                    logic lock, logic [31:0] data,
                                    logic known = 1'b0, res_t res = RES_IDLE);
    row_t r;
    r = '0;
    r.kind = ROW_BEAT;
    r.req = req;
    r.page = page;
    r.addr = addr;
    r.lock = lock;
    r.data = data;
    r.known = known;
    r.res = res;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [CIDX_W-1:0] idx, logic [CLK_W-1:0] val);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic row_t finish_row();
    row_t r;
    r = '0;
    r.kind = ROW_FINISH;
    return r;
  endfunction

  // random timing value: mostly short, sometimes zero, now and then long
  function automatic logic [CLK_W-1:0] pick_len(logic [CIDX_W-1:0] idx);
    int unsigned p;
    logic [CLK_W-1:0] v;
    p = $urandom_range(99);
    if (idx == CFG_WAIT || idx == CFG_PROG) begin
      v = CLK_W'($urandom_range(12, 1));
    end else begin
      v = CLK_W'($urandom_range(6, 1));
      v[CLK_W-1:SHORT_W] = 2'($urandom);
    end
    if (p < 8) begin
      v = '0;
    end else if (p < 13 && (idx == CFG_WAIT || idx == CFG_PROG)) begin
      v = CLK_W'($urandom_range(40, 20));
    end else if (p < 13 && idx == CFG_SGAP) begin
      v = 10'h0FF;
    end
    return v;
  endfunction

  task automatic in_idle();
    repeat (gap_len()) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  task automatic send_beat(logic [1:0] req, logic page, logic [2:0] addr, logic lock,
                           logic [31:0] data, logic known, res_t typed);
    res_t r;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {3'b000, data, lock, addr, page};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = gate_predict(req, page, addr, lock, data);
    gate_q.push_back(known ? typed : r);
    n_beats++;
    if (r.rejected) n_rejects++;
    else if (req == REQ_WRITE) n_writes++;
    else if (req == REQ_RESET) n_resets++;
  endtask

  // mostly well-formed: requests when idle, ticks while busy, a few stray requests
  task automatic send_random_beat();
    logic [1:0] req;
    int unsigned p;
    p = $urandom_range(99);
    if (seq_ph == PH_IDLE) begin
      req = (p < 65) ? REQ_WRITE : (p < 85) ? REQ_RESET : (p < 95) ? REQ_TICK : REQ_SPARE;
    end else begin
      req = (p < 2) ? REQ_WRITE : (p < 4) ? REQ_RESET : (p < 12) ? REQ_SPARE : REQ_TICK;
    end
    in_idle();
    send_beat(req, 1'($urandom), 3'($urandom), 1'($urandom), $urandom, 1'b0, RES_IDLE);
  endtask

  task automatic run_to_idle();
    while (seq_ph != PH_IDLE) send_random_beat();
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (gate_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [CLK_W-1:0] val);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_WAIT: seq_cfg.wait_clocks = val;
      CFG_SGAP: seq_cfg.start_gap_clocks = val[SHORT_W-1:0];
      CFG_WGAP: seq_cfg.write_gap_clocks = val[SHORT_W-1:0];
      CFG_ZERO: seq_cfg.zero_on_clocks = val[SHORT_W-1:0];
      CFG_ONE:  seq_cfg.one_on_clocks = val[SHORT_W-1:0];
      CFG_PROG: seq_cfg.program_clocks = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    res_t exp_r;
    string names[4];
    names = '{"field_on", "busy_res", "done_res", "rejected"};
    if (rst_n && out_tvalid && out_tready) begin
      if (gate_q.size() == 0) begin
        $error("result beat with no expectation waiting: %h", out_tdata);
        n_errors++;
      end else begin
        exp_r = gate_q.pop_front();
        n_checked++;
        for (int b = 0; b < 4; b++) begin
          if (out_tdata[b] !== exp_r[b]) begin
            $error("%s: expected %0b, got %0b", names[b], exp_r[b], out_tdata[b]);
            n_errors++;
          end
        end
      end
    end
  end

  initial begin
    out_tready = 1'b1;
    forever begin
      repeat (gap_len()) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
    end
  end

  initial begin
    #100000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = REQ_TICK;
    cfg_valid = 1'b0;
    cfg_index = CFG_WAIT;
    cfg_data = '0;
    quiet = 1'b0;
    n_beats = 0;
    n_writes = 0;
    n_resets = 0;
    n_rejects = 0;
    n_checked = 0;
    n_errors = 0;
    seq_cfg = '{WAIT_RST, SGAP_RST, WGAP_RST, ZERO_RST, ONE_RST, PROG_RST};
    seq_ph = PH_IDLE;
    seq_left = '0;
    seq_bits = '0;
    seq_frame = '0;
    seq_reprog = 1'b0;

    // defaults after reset, busy rejects, then zero lengths and long lengths
    plan.push_back(beat_row(REQ_TICK, 1'b0, 3'd0, 1'b0, 32'h0, 1'b1, RES_IDLE));
    plan.push_back(beat_row(REQ_SPARE, 1'b1, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1, RES_IDLE));
    plan.push_back(beat_row(REQ_RESET, 1'b0, 3'd0, 1'b0, 32'h0, 1'b1, RES_GAP));
    plan.push_back(beat_row(REQ_WRITE, 1'b1, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1, RES_GAP_REJ));
    plan.push_back(beat_row(REQ_RESET, 1'b1, 3'd3, 1'b0, 32'h1234_5678, 1'b1, RES_GAP_REJ));
    plan.push_back(finish_row());
    plan.push_back(cfg_row(CFG_WAIT, 10'h000));
    plan.push_back(cfg_row(CFG_SGAP, 10'h300));
    plan.push_back(cfg_row(CFG_WGAP, 10'h300));
    plan.push_back(cfg_row(CFG_ZERO, 10'h100));
    plan.push_back(cfg_row(CFG_ONE, 10'h200));
    plan.push_back(cfg_row(CFG_PROG, 10'h000));
    plan.push_back(cfg_row(CFG_SPARE_LO, 10'h3FF));
    plan.push_back(cfg_row(CFG_SPARE_HI, 10'h155));
    // a zero wait still lasts one clock with the field on
    plan.push_back(beat_row(REQ_WRITE, 1'b1, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1, RES_WAIT));
    plan.push_back(beat_row(REQ_TICK, 1'b0, 3'd5, 1'b1, 32'h5A5A_5A5A));
    plan.push_back(finish_row());
    plan.push_back(beat_row(REQ_WRITE, 1'b0, 3'd0, 1'b0, 32'h0));
    plan.push_back(beat_row(REQ_WRITE, 1'b1, 3'd4, 1'b1, 32'hDEAD_BEEF));
    plan.push_back(finish_row());
    plan.push_back(beat_row(REQ_WRITE, 1'b1, 3'd5, 1'b0, 32'hA5A5_0F0F));
    plan.push_back(finish_row());
    plan.push_back(beat_row(REQ_RESET, 1'b1, 3'd2, 1'b1, 32'h0F0F_A5A5));
    plan.push_back(finish_row());
    plan.push_back(cfg_row(CFG_WAIT, 10'h001));
    plan.push_back(cfg_row(CFG_SGAP, 10'h001));
    plan.push_back(cfg_row(CFG_WGAP, 10'h001));
    plan.push_back(cfg_row(CFG_ZERO, 10'h001));
    plan.push_back(cfg_row(CFG_ONE, 10'h001));
    plan.push_back(cfg_row(CFG_PROG, 10'h200));
    plan.push_back(beat_row(REQ_WRITE, 1'b0, 3'd2, 1'b1, 32'h8000_0001));
    plan.push_back(finish_row());
    plan.push_back(cfg_row(CFG_ONE, 10'h0FF));
    plan.push_back(beat_row(REQ_RESET, 1'b0, 3'd6, 1'b0, 32'h7FFF_FFFE));
    plan.push_back(finish_row());

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_BEAT: begin
          in_idle();
          send_beat(plan[i].req, plan[i].page, plan[i].addr, plan[i].lock, plan[i].data,
                    plan[i].known, plan[i].res);
        end
        ROW_FINISH: run_to_idle();
        default: cfg_write(plan[i].idx, plan[i].val);
      endcase
    end

    // random phases, each with fresh timing; the second phase runs without idling
    for (int ph = 0; ph < 4; ph++) begin
      quiet = (ph % 3 == 1);
      for (int r = 0; r <= int'(CFG_PROG); r++) begin
        cfg_write(CIDX_W'(r), pick_len(CIDX_W'(r)));
      end
      if ($urandom_range(3) == 0) cfg_write($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                                            10'($urandom));
      repeat (75) send_random_beat();
      run_to_idle();
    end
    quiet = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    $display("checked %0d gate results over %0d beats: %0d block writes, %0d reset commands,",
             n_checked, n_beats, n_writes, n_resets);
    $display("%0d rejected requests; timing at reset, zero, short, random and long values",
             n_rejects);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/t55wg_pkg.sv
design/t55wg_cfg_regs.sv
design/t55wg_seq.sv
design/t55xx_write_gap_modulator.sv
verif/tb_top.sv
